@@ rtl/lurs_pkg.sv @@
// Shared types and constants for the largest usable region selector.
// No dependencies; imported by lurs_clip and largest_usable_region_selector_top.

package lurs_pkg;

   // address width of everything kept below and at 4 GiB
   localparam int ADDR_W = 33;
   localparam int CSR_IDX_W = 1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_FLOOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE     = 1'b1;

   // reset values of the registers
   localparam logic [ADDR_W-1:0] KERNEL_FLOOR_RST = 33'h0;
   localparam logic [ADDR_W-1:0] MIN_SIZE_RST     = 33'h0_1000_0000;

   // top of the usable window
   localparam logic [ADDR_W-1:0] WINDOW_END = 33'h1_0000_0000;

   // memory type code for usable ram
   localparam logic [31:0] KIND_USABLE = 32'd1;

   // clamped but not yet aligned candidate region
   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
   } cand_type;

endpackage

@@ rtl/largest_usable_region_selector_top.sv @@
// Largest usable region selector: scans memory-map entries, keeps the widest one.
// A final request goes from the input register into the result register once the result
// register has room. Throughput: one request per cycle; clamp, align and compare run between
// the input register and the kept region / result register. A final request waits
// only while an earlier result is stalled. Reset (synchronous, active high): registers
// empty, kept region 0..0, kernel floor 0, minimum size 256 MiB. Uses lurs_pkg, lurs_clip.

module largest_usable_region_selector_top #(
   parameter int REGION_ALIGN = 16   // power of two, 1 to 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [63:0]                    req_region_base,
   input  logic [63:0]                    req_region_length,
   input  logic [31:0]                    req_region_kind,
   input  logic                           req_is_final,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [lurs_pkg::ADDR_W-1:0]    rsp_heap_start,
   output logic [lurs_pkg::ADDR_W-1:0]    rsp_heap_limit,
   // configuration port
   input  logic                           csr_write_en,
   input  logic [lurs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lurs_pkg::ADDR_W-1:0]    csr_wdata
);
   import lurs_pkg::*;

   localparam logic [ADDR_W-1:0] ALIGN_MASK = ADDR_W'(REGION_ALIGN - 1);

   // configuration registers
   logic [ADDR_W-1:0] kernel_floor_ff;
   logic [ADDR_W-1:0] min_size_ff;

   // input register
   logic              s1_valid_ff;
   logic [63:0]       s1_base_ff;
   logic [63:0]       s1_length_ff;
   logic              s1_kind_ok_ff;
   logic              s1_final_ff;

   // clamped and aligned candidate
   cand_type          cand;
   logic [ADDR_W-1:0] lo_al;
   logic [ADDR_W-1:0] hi_al;
   logic [ADDR_W-1:0] cand_width;
   logic              cand_ok;

   // kept region
   logic [ADDR_W-1:0] best_start_ff;
   logic [ADDR_W-1:0] best_limit_ff;
   logic [ADDR_W-1:0] best_width_ff;
   logic [ADDR_W-1:0] best_start_in;
   logic [ADDR_W-1:0] best_limit_in;
   logic [ADDR_W-1:0] best_width_in;
   logic              take;
   logic              found_in;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [ADDR_W-1:0] rsp_start_ff;
   logic [ADDR_W-1:0] rsp_limit_ff;

   // flow control
   logic out_ready;
   logic s1_go;
   logic retire;
   logic emit;

   // only a final request needs room in the result register
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = !s1_valid_ff || !s1_final_ff || out_ready;
   assign req_stall = !s1_go;
   assign retire    = s1_valid_ff && s1_go;
   assign emit      = retire && s1_final_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_floor_ff <= KERNEL_FLOOR_RST;
         min_size_ff     <= MIN_SIZE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KERNEL_FLOOR: kernel_floor_ff <= csr_wdata;
            CSR_MIN_SIZE:     min_size_ff     <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // input register capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && req_valid) begin
         s1_base_ff    <= req_region_base;
         s1_length_ff  <= req_region_length;
         s1_kind_ok_ff <= (req_region_kind == KIND_USABLE);
         s1_final_ff   <= req_is_final;
      end
   end

   // clamp to the window
   lurs_clip u_clip (
      .base         (s1_base_ff),
      .length       (s1_length_ff),
      .kind_ok      (s1_kind_ok_ff),
      .kernel_floor (kernel_floor_ff),
      .cand         (cand)
   );

   // align start up and end down
   assign lo_al      = (cand.lo + ALIGN_MASK) & ~ALIGN_MASK;
   assign hi_al      = cand.hi & ~ALIGN_MASK;
   assign cand_ok    = cand.ok && (hi_al > lo_al);
   assign cand_width = hi_al - lo_al;

   // keep the strictly wider region
   always_comb begin
      take          = cand_ok && (cand_width > best_width_ff);
      best_start_in = take ? lo_al      : best_start_ff;
      best_limit_in = take ? hi_al      : best_limit_ff;
      best_width_in = take ? cand_width : best_width_ff;
      found_in      = (best_width_in != '0) && (best_width_in >= min_size_ff);
   end

   // kept region is cleared after a final request reports it
   always_ff @(posedge clock) begin
      if (reset) begin
         best_start_ff <= '0;
         best_limit_ff <= '0;
         best_width_ff <= '0;
      end else if (emit) begin
         best_start_ff <= '0;
         best_limit_ff <= '0;
         best_width_ff <= '0;
      end else if (retire) begin
         best_start_ff <= best_start_in;
         best_limit_ff <= best_limit_in;
         best_width_ff <= best_width_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff <= found_in;
         rsp_start_ff <= best_start_in;
         rsp_limit_ff <= best_limit_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_heap_start = rsp_start_ff;
   assign rsp_heap_limit = rsp_limit_ff;

   // kept width always matches the kept bounds
   a_width_tracks : assert property (@(posedge clock) disable iff (reset)
      best_width_ff == best_limit_ff - best_start_ff)
      else $error("kept width out of step with kept region");

   // a reported region is cleared on the next cycle
   a_clear_after_emit : assert property (@(posedge clock) disable iff (reset)
      emit |=> (best_width_ff == '0) && (best_start_ff == '0))
      else $error("kept region not cleared after final request");

   // a found region is nonempty and aligned
   a_found_sane : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |->
         (rsp_limit_ff > rsp_start_ff) && ((rsp_start_ff & ALIGN_MASK) == '0))
      else $error("found region empty or misaligned");

endmodule

@@ rtl/lurs_clip.sv @@
// Clamp of one memory-map entry to the window [kernel floor, 4 GiB).
// Depends on lurs_pkg for cand_type and address constants.

module lurs_clip (
   input  logic [63:0]                 base,
   input  logic [63:0]                 length,
   input  logic                        kind_ok,
   input  logic [lurs_pkg::ADDR_W-1:0] kernel_floor,
   output lurs_pkg::cand_type          cand
);
   import lurs_pkg::*;

   logic [64:0]       end_sum;
   logic              end_big;
   logic              base_big;
   logic [ADDR_W-1:0] hi;
   logic [ADDR_W-1:0] lo;

   // end computed with carry, so a wrap counts as saturated
   assign end_sum  = {1'b0, base} + {1'b0, length};
   assign end_big  = (end_sum[64:32] != 33'd0);
   assign hi       = end_big ? WINDOW_END : {1'b0, end_sum[31:0]};

   // start raised to the floor; a base at or above 2^33 is always past the end
   assign base_big = (base[63:ADDR_W] != '0);
   assign lo       = (base[ADDR_W-1:0] > kernel_floor) ? base[ADDR_W-1:0] : kernel_floor;

   always_comb begin
      cand.ok = kind_ok && (length != 64'd0) && !base_big && (lo < hi);
      cand.lo = lo;
      cand.hi = hi;
   end

endmodule

@@ test/largest_usable_region_selector_top_test.sv @@
// Testbench for largest_usable_region_selector_top: memory-map requests with random idling,
// a region tracker predicts each chosen heap region and checks it. Depends on lurs_pkg.
`timescale 1ns / 1ps

module largest_usable_region_selector_top_test;
   import lurs_pkg::*;

   localparam int REGION_ALIGN = 16;
   localparam logic [63:0] ALIGN_MASK = ~(64'(REGION_ALIGN) - 64'd1);
   localparam logic [63:0] WINDOW_TOP = {31'b0, WINDOW_END};
   localparam int SETTLE_CYCLES = 8;
   localparam int TARGET_ITEMS = 1100;
   localparam int PHASES = 8;

   typedef struct {
      logic [63:0] base;
      logic [63:0] length;
      logic [31:0] kind;
   } map_entry_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] limit;
   } heap_choice_type;

   // keeps the widest usable region and the chosen regions still to come
   class heap_region_tracker_type;
      logic [ADDR_W-1:0] floor_addr;
      logic [ADDR_W-1:0] min_size;
      logic [ADDR_W-1:0] best_start;
      logic [ADDR_W-1:0] best_limit;
      heap_choice_type pending_choices[$];
      int unsigned errors;

      function new();
         floor_addr = KERNEL_FLOOR_RST;
         min_size = MIN_SIZE_RST;
         best_start = '0;
         best_limit = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
         if (idx == CSR_KERNEL_FLOOR) begin
            floor_addr = value;
         end else if (idx == CSR_MIN_SIZE) begin
            min_size = value;
         end
      endfunction

      // an accepted request: fold the entry into the kept region
      function void note_entry(map_entry_type e, logic last_mark);
         logic [64:0] sum;
         logic [63:0] end_addr;
         logic [63:0] lo;
         logic [63:0] hi;
         heap_choice_type choice;
         sum = {1'b0, e.base} + {1'b0, e.length};
         end_addr = sum[64] ? '1 : sum[63:0];
         hi = (end_addr < WINDOW_TOP) ? end_addr : WINDOW_TOP;
         lo = (e.base > {31'b0, floor_addr}) ? e.base : {31'b0, floor_addr};
         if (e.kind == KIND_USABLE && e.length != 0 && lo < hi) begin
            lo = (lo + 64'(REGION_ALIGN) - 64'd1) & ALIGN_MASK;
            hi = hi & ALIGN_MASK;
            // strictly wider only, so ties keep the earlier region
            if (hi > lo && (hi - lo) > {31'b0, best_limit - best_start}) begin
               best_start = lo[ADDR_W-1:0];
               best_limit = hi[ADDR_W-1:0];
            end
         end
         if (last_mark) begin
            choice.found = (best_limit > best_start) && (best_limit - best_start >= min_size);
            choice.start = best_start;
            choice.limit = best_limit;
            pending_choices.push_back(choice);
            best_start = '0;
            best_limit = '0;
         end
      endfunction

      // an accepted result against the oldest chosen region
      function void check_choice(logic found, logic [ADDR_W-1:0] start,
                                 logic [ADDR_W-1:0] limit);
         heap_choice_type want;
         if (pending_choices.size() == 0) begin
            $display("%0t: unexpected result found=%0d start=%h limit=%h",
                     $time, found, start, limit);
            errors++;
            return;
         end
         want = pending_choices.pop_front();
         if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
            errors++;
         end
         if (start !== want.start) begin
            $display("%0t: heap_start expected %h actual %h", $time, want.start, start);
            errors++;
         end
         if (limit !== want.limit) begin
            $display("%0t: heap_limit expected %h actual %h", $time, want.limit, limit);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [63:0] req_region_base;
   logic [63:0] req_region_length;
   logic [31:0] req_region_kind;
   logic req_is_final;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_found;
   logic [ADDR_W-1:0] rsp_heap_start;
   logic [ADDR_W-1:0] rsp_heap_limit;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   heap_region_tracker_type tracker = new();
   bit req_steady;
   bit rsp_steady;
   int stall_left;

   largest_usable_region_selector_top #(.REGION_ALIGN(REGION_ALIGN)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_region_base(req_region_base),
      .req_region_length(req_region_length),
      .req_region_kind(req_region_kind),
      .req_is_final(req_is_final),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_heap_start(rsp_heap_start),
      .rsp_heap_limit(rsp_heap_limit),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   // idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic map_entry_type make_entry(logic [63:0] base, logic [63:0] length,
                                                logic [31:0] kind);
      map_entry_type e;
      e.base = base;
      e.length = length;
      e.kind = kind;
      return e;
   endfunction

   // random entry, weighted toward usable ram under 4 GiB
   function automatic map_entry_type pick_entry();
      map_entry_type e;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) e.kind = KIND_USABLE;
      else if (r < 85) e.kind = '0;
      else if (r < 90) e.kind = '1;
      else e.kind = $urandom;
      r = $urandom_range(0, 99);
      if (r < 50) e.base = {32'h0, $urandom};
      else if (r < 65) e.base = {31'b0, tracker.floor_addr} + 64'($urandom_range(0, 4096))
                                - 64'd2048;
      else if (r < 75) e.base = 64'($urandom_range(0, 255));
      else if (r < 85) e.base = {32'h0, 32'hFFFF_FFFF - $urandom_range(0, 4095)};
      else e.base = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 8) e.length = '0;
      else if (r < 25) e.length = 64'($urandom_range(1, 64));
      else if (r < 70) e.length = 64'($urandom) >> $urandom_range(0, 16);
      else if (r < 85) e.length = 64'(33'({$urandom, $urandom}));
      else if (r < 93) e.length = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
      else e.length = {$urandom, $urandom};
      return e;
   endfunction

   // one request, held until accepted, then an optional gap
   task automatic send_entry(map_entry_type e, logic last_mark);
      int gap;
      req_valid <= 1'b1;
      req_region_base <= e.base;
      req_region_length <= e.length;
      req_region_kind <= e.kind;
      req_is_final <= last_mark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_entry(e, last_mark);
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every chosen region, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, then csr_write_en drops and the csr port idles
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // one random map ending on its final entry
   task automatic random_map(inout int counted);
      int n;
      map_entry_type e;
      logic last_mark;
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      req_steady = ($urandom_range(0, 5) == 0);
      rsp_steady = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n; i++) begin
         e = pick_entry();
         last_mark = (i == n - 1);
         send_entry(e, last_mark);
         counted++;
      end
   endtask

   // result side: check accepted results and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            tracker.check_choice(rsp_found, rsp_heap_start, rsp_heap_limit);
         end
         if (stall_left == 0 && !rsp_steady && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int counted;
      reset = 1'b1;
      req_valid = 1'b0;
      req_region_base = '0;
      req_region_length = '0;
      req_region_kind = '0;
      req_is_final = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_KERNEL_FLOOR;
      csr_wdata = '0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      counted = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers
      // nothing qualified yet
      send_entry(make_entry(64'h0, 64'h0, KIND_USABLE), 1'b1);
      // exactly the minimum size, then a narrower one
      send_entry(make_entry(64'h1000_0000, 64'h1000_0000, KIND_USABLE), 1'b0);
      send_entry(make_entry(64'h7, 64'h20, KIND_USABLE), 1'b1);
      // whole window
      send_entry(make_entry(64'h0, WINDOW_TOP, KIND_USABLE), 1'b1);
      // tie keeps the first, final entry of another kind
      send_entry(make_entry(64'h100, 64'h1000, KIND_USABLE), 1'b0);
      send_entry(make_entry(64'h10000, 64'h1000, KIND_USABLE), 1'b0);
      send_entry(make_entry(64'h0, 64'h4000_0000, 32'd2), 1'b1);
      // start above 4 GiB
      send_entry(make_entry(64'h1_0000_0010, 64'h1000, KIND_USABLE), 1'b1);
      // end saturates, start far above the window
      send_entry(make_entry(64'hFFFF_FFFF_FFFF_0000, '1, KIND_USABLE), 1'b0);
      send_entry(make_entry('1, 64'h1, KIND_USABLE), 1'b1);
      // end saturates, clamped to 4 GiB
      send_entry(make_entry(64'h10, '1, KIND_USABLE), 1'b1);
      // empty once aligned
      send_entry(make_entry(64'h11, 64'hE, KIND_USABLE), 1'b1);
      // other kinds and a zero length are skipped
      send_entry(make_entry(64'h0, 64'h1000, 32'h0), 1'b0);
      send_entry(make_entry(64'h0, 64'h1000, 32'hFFFF_FFFF), 1'b0);
      send_entry(make_entry(64'h2000, 64'h0, KIND_USABLE), 1'b1);
      // region below the minimum size
      send_entry(make_entry(64'h1000, 64'h100, KIND_USABLE), 1'b1);
      drain();

      // directed: start raised to the kernel floor
      write_reg(CSR_KERNEL_FLOOR, 33'h0_2000_0000);
      write_reg(CSR_MIN_SIZE, 33'h10);
      send_entry(make_entry(64'h0, 64'h4000_0000, KIND_USABLE), 1'b0);
      send_entry(make_entry(64'h1FFF_FFF0, 64'h18, KIND_USABLE), 1'b1);
      send_entry(make_entry(64'h2000_0001, 64'h20, KIND_USABLE), 1'b1);

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(CSR_KERNEL_FLOOR, KERNEL_FLOOR_RST);
               write_reg(CSR_MIN_SIZE, MIN_SIZE_RST);
            end
            1: begin
               write_reg(CSR_KERNEL_FLOOR, WINDOW_END);
               write_reg(CSR_MIN_SIZE, '0);
            end
            2: begin
               write_reg(CSR_KERNEL_FLOOR, 33'($urandom) & ~33'hFFF);
               write_reg(CSR_MIN_SIZE, WINDOW_END);
            end
            3: begin
               write_reg(CSR_KERNEL_FLOOR, 33'h1000);
               write_reg(CSR_MIN_SIZE, 33'($urandom_range(0, 1 << 20)));
            end
            4: begin
               write_reg(CSR_KERNEL_FLOOR, 33'({$urandom, $urandom}));
               write_reg(CSR_MIN_SIZE, 33'({$urandom, $urandom}));
            end
            5: begin
               write_reg(CSR_KERNEL_FLOOR, '1);
               write_reg(CSR_MIN_SIZE, '1);
            end
            6: begin
               write_reg(CSR_KERNEL_FLOOR, 33'($urandom));
               write_reg(CSR_MIN_SIZE, 33'($urandom_range(0, 32'h1000_0000)));
            end
            default: begin
               write_reg(CSR_KERNEL_FLOOR, '0);
               write_reg(CSR_MIN_SIZE, '0);
            end
         endcase
         while (counted < (ph + 1) * (TARGET_ITEMS / PHASES)) random_map(counted);
      end

      // wind down
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      drain();
      if (tracker.pending_choices.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, tracker.pending_choices.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
